FILE: hw/rtl/ptx_pkg.sv
// Shared types and codes for the persistent trie range max-XOR block.
// No dependencies; ptx_step, the top level and ptx_chk import this package.
`timescale 1ns / 1ps

package ptx_pkg;

    // Fixed field widths of the request and response beats.
    localparam int VALUE_W  = 24;
    localparam int RANGE_W  = 10;
    localparam int STATUS_W = 2;

    // Request operation codes.
    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    // Response status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // One request beat.
    typedef struct packed {
        logic               op;
        logic [VALUE_W-1:0] value;
        logic [RANGE_W-1:0] range_low;
        logic [RANGE_W-1:0] range_high;
    } ptx_req_t;

    // One response beat.
    typedef struct packed {
        logic [VALUE_W-1:0]  max_xor;
        logic [STATUS_W-1:0] status;
    } ptx_rsp_t;

    // Control for one pass of the shared level unit.
    typedef struct packed {
        logic query;
        logic key_bit;
    } ptx_step_ctl_t;

endpackage

FILE: hw/rtl/ptx_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module ptx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [AW-1:0]         waddr,
    input  logic [WIDTH-1:0]      wdata,
    input  logic [AW-1:0]         raddr,
    output logic [WIDTH-1:0]      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hw/rtl/ptx_step.sv
// Shared per-level unit of the trie walk: decodes a node word, picks the
// next node and forms the path-copied node word. Depends on ptx_pkg.
`timescale 1ns / 1ps

module ptx_step
    import ptx_pkg::*;
#(
    parameter int NW       = 15,
    parameter int VERW     = 10,
    parameter int KEY_BITS = 24
) (
    input  logic [NW-1:0]          node_addr,
    input  logic [2*(NW+VERW)-1:0] node_word,
    input  ptx_step_ctl_t          ctl,
    input  logic [VERW-1:0]        lim,
    input  logic [VERW-1:0]        ver,
    input  logic [NW-1:0]          fresh,
    output logic [NW-1:0]          next_addr,
    output logic [2*(NW+VERW)-1:0] wr_word,
    output logic                   take
);

    localparam logic [NW-1:0] LEAF0 = NW'(KEY_BITS + 1);

    logic [NW-1:0]   c0;
    logic [NW-1:0]   c1;
    logic [VERW-1:0] s0;
    logic [VERW-1:0] s1;
    logic [NW-1:0]   nx;
    logic [VERW-1:0] nx_stamp;

    // Node 0 and the version 0 chain are never stored; they are decoded
    // from the address. Version 0 always descends through child 0.
    always_comb
    begin
        if (node_addr <= LEAF0)
        begin
            c1 = '0;
            s1 = '0;
            s0 = '0;
            if (node_addr != '0 && node_addr != LEAF0)
            begin
                c0 = node_addr + NW'(1);
            end
            else
            begin
                c0 = '0;
            end
        end
        else
        begin
            s0 = node_word[VERW-1:0];
            c0 = node_word[NW+VERW-1:VERW];
            s1 = node_word[NW+2*VERW-1:NW+VERW];
            c1 = node_word[2*(NW+VERW)-1:NW+2*VERW];
        end
    end

    // Greedy choice for a query, plain descent along the key for a build.
    always_comb
    begin
        nx       = ctl.key_bit ? c0 : c1;
        nx_stamp = ctl.key_bit ? s0 : s1;
        take     = ctl.query && (nx != '0) && (nx_stamp >= lim);
        if (take)
        begin
            next_addr = nx;
        end
        else
        begin
            next_addr = ctl.key_bit ? c1 : c0;
        end
    end

    // New node: the key side points at the next fresh node, the other side
    // is copied from the previous version.
    always_comb
    begin
        if (ctl.key_bit)
        begin
            wr_word = {fresh, ver, c0, s0};
        end
        else
        begin
            wr_word = {c1, s1, fresh, ver};
        end
    end

endmodule

FILE: hw/rtl/persistent_trie_range_max_xor_top.sv
// Channel  Dir  Handshake              Beat
// req      in   req_valid/req_ready    ptx_req_t: op, value, range_low, range_high
// rsp      out  rsp_valid/rsp_ready    ptx_rsp_t: max_xor, status
//
// An append or a query is taken only while the block is idle, so a new request
// waits until the last one is through; one trie level per cycle, through the
// node RAM read port and the shared level unit.
// Errors (bad range, full store) skip the walk. No clearing pass after reset.
// A response not yet taken holds the next result in its final state.
// Depends on ptx_pkg, ptx_ram and ptx_step.
`timescale 1ns / 1ps

module persistent_trie_range_max_xor_top
    import ptx_pkg::*;
#(
    parameter int MAX_VERSIONS = 1024,
    parameter int KEY_BITS     = 24
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  ptx_req_t req_data,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output ptx_rsp_t rsp_data
);

    localparam int NODE_CAP = MAX_VERSIONS * (KEY_BITS + 1) + 1;
    localparam int NW       = $clog2(NODE_CAP);
    localparam int VERW     = $clog2(MAX_VERSIONS);
    localparam int LW       = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
    localparam int CW       = (VERW > RANGE_W) ? VERW : RANGE_W;
    localparam int XW       = (KEY_BITS > VALUE_W) ? KEY_BITS : VALUE_W;
    localparam int WORD_W   = 2 * (NW + VERW);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ROOT = 3'd1;
    localparam logic [2:0] S_WALK = 3'd2;
    localparam logic [2:0] S_LEAF = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]          state_reg;
    logic [VERW-1:0]     vc_reg;
    logic [KEY_BITS-1:0] prefix_reg;
    logic [NW-1:0]       next_free_reg;
    logic                op_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [VERW-1:0]     lim_reg;
    logic [LW-1:0]       lvl_reg;
    logic [KEY_BITS-1:0] ans_reg;
    logic [NW-1:0]       node_addr_reg;
    logic [VERW-1:0]     root_addr_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                rsp_valid_reg;
    ptx_rsp_t            rsp_reg;

    logic                accept;
    logic [XW-1:0]       val_ext;
    logic [KEY_BITS-1:0] val_k;
    logic                full;
    logic                bad_range;
    logic [VERW-1:0]     roots_raddr;
    logic [NW-1:0]       roots_rdata;
    logic                roots_we;
    logic [NW-1:0]       root;
    logic [NW-1:0]       node_raddr;
    logic [WORD_W-1:0]   node_rdata;
    logic                node_we;
    logic [WORD_W-1:0]   node_wdata;
    ptx_step_ctl_t       step_ctl;
    logic [NW-1:0]       step_next;
    logic [WORD_W-1:0]   step_word;
    logic                step_take;
    logic [XW-1:0]       ans_ext;
    logic                rsp_free;

    assign accept    = req_valid && req_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;
    assign rsp_free  = !rsp_valid_reg || rsp_ready;

    // Request decode and checks.
    assign val_ext   = XW'(req_data.value);
    assign val_k     = val_ext[KEY_BITS-1:0];
    assign full      = (vc_reg == VERW'(MAX_VERSIONS - 1));
    assign bad_range = (req_data.range_low == '0) || (req_data.range_high == '0) ||
                       (req_data.range_low > req_data.range_high) ||
                       (CW'(req_data.range_high) > CW'(vc_reg));

    // Version root table; entry 0 is the fixed root of version 0.
    assign roots_raddr = (req_data.op == OP_APPEND) ? vc_reg
                                                    : VERW'(req_data.range_high - RANGE_W'(1));
    assign roots_we    = accept && (req_data.op == OP_APPEND) && !full;
    assign root        = (root_addr_reg == '0) ? NW'(1) : roots_rdata;

    ptx_ram #(
        .WIDTH (NW),
        .DEPTH (MAX_VERSIONS)
    ) u_roots (
        .clk   (clk),
        .we    (roots_we),
        .waddr (vc_reg + VERW'(1)),
        .wdata (next_free_reg),
        .raddr (roots_raddr),
        .rdata (roots_rdata)
    );

    // Shared level unit.
    assign step_ctl.query   = (op_reg == OP_QUERY);
    assign step_ctl.key_bit = key_reg[lvl_reg];

    ptx_step #(
        .NW       (NW),
        .VERW     (VERW),
        .KEY_BITS (KEY_BITS)
    ) u_step (
        .node_addr (node_addr_reg),
        .node_word (node_rdata),
        .ctl       (step_ctl),
        .lim       (lim_reg),
        .ver       (vc_reg),
        .fresh     (next_free_reg + NW'(1)),
        .next_addr (step_next),
        .wr_word   (step_word),
        .take      (step_take)
    );

    // Node store: children with the newest version of each child.
    assign node_raddr = (state_reg == S_ROOT) ? root : step_next;
    assign node_we    = ((state_reg == S_WALK) && (op_reg == OP_APPEND)) ||
                        (state_reg == S_LEAF);
    assign node_wdata = (state_reg == S_LEAF) ? '0 : step_word;

    ptx_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NODE_CAP)
    ) u_nodes (
        .clk   (clk),
        .we    (node_we),
        .waddr (next_free_reg),
        .wdata (node_wdata),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    assign ans_ext = XW'(ans_reg);

    // Sequencer and control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            vc_reg        <= '0;
            prefix_reg    <= '0;
            next_free_reg <= NW'(KEY_BITS + 2);
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            // A taken beat is dropped unless a new one replaces it this cycle.
            if (rsp_valid_reg && rsp_ready && (state_reg != S_FIN))
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (req_data.op == OP_APPEND)
                        begin
                            if (full)
                            begin
                                state_reg <= S_FIN;
                            end
                            else
                            begin
                                vc_reg     <= vc_reg + VERW'(1);
                                prefix_reg <= prefix_reg ^ val_k;
                                state_reg  <= S_ROOT;
                            end
                        end
                        else if (bad_range)
                        begin
                            state_reg <= S_FIN;
                        end
                        else
                        begin
                            state_reg <= S_ROOT;
                        end
                    end
                end
                S_ROOT:
                begin
                    state_reg <= S_WALK;
                end
                S_WALK:
                begin
                    if (op_reg == OP_APPEND)
                    begin
                        next_free_reg <= next_free_reg + NW'(1);
                    end
                    if (lvl_reg == '0)
                    begin
                        state_reg <= (op_reg == OP_APPEND) ? S_LEAF : S_FIN;
                    end
                end
                S_LEAF:
                begin
                    next_free_reg <= next_free_reg + NW'(1);
                    state_reg     <= S_FIN;
                end
                S_FIN:
                begin
                    if (rsp_free)
                    begin
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Item payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg        <= req_data.op;
            ans_reg       <= '0;
            lim_reg       <= VERW'(req_data.range_low - RANGE_W'(1));
            root_addr_reg <= roots_raddr;
            if (req_data.op == OP_APPEND)
            begin
                key_reg    <= prefix_reg ^ val_k;
                status_reg <= full ? ST_FULL : ST_OK;
            end
            else
            begin
                key_reg    <= prefix_reg ^ val_k;
                status_reg <= bad_range ? ST_RANGE : ST_OK;
            end
        end
        if (state_reg == S_ROOT)
        begin
            node_addr_reg <= root;
            lvl_reg       <= LW'(KEY_BITS - 1);
        end
        if (state_reg == S_WALK)
        begin
            node_addr_reg <= step_next;
            lvl_reg       <= lvl_reg - LW'(1);
            if (op_reg == OP_QUERY)
            begin
                ans_reg[lvl_reg] <= step_take;
            end
        end
        if ((state_reg == S_FIN) && rsp_free)
        begin
            rsp_reg.max_xor <= ans_ext[VALUE_W-1:0];
            rsp_reg.status  <= status_reg;
        end
    end

endmodule

FILE: hw/rtl/ptx_chk.sv
// Port-level checker for the persistent trie range max-XOR block, with
// its bind to the top level. Depends on ptx_pkg.
`timescale 1ns / 1ps

module ptx_chk
    import ptx_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     req_valid,
    input logic     req_ready,
    input logic     rsp_valid,
    input logic     rsp_ready,
    input ptx_rsp_t rsp_data
);

    // Only the three defined status codes are ever reported.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_data.status == ST_OK || rsp_data.status == ST_RANGE ||
                       rsp_data.status == ST_FULL))
        else $error("undefined status code on rsp");

    // An error beat never carries a nonzero result.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_data.status != ST_OK) |-> (rsp_data.max_xor == '0))
        else $error("error response with nonzero max_xor");

    // The block holds one item at a time: it is busy right after a beat.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request taken while an item is in flight");

    // A stalled response beat holds.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
        else $error("rsp beat dropped or changed while stalled");

endmodule

bind persistent_trie_range_max_xor_top ptx_chk u_ptx_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
);
